// ----- rtl/turing_machine_stepper_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the Turing machine stepper
// Shorthand for the clocked implication checks used in the RTL.
// ---------------------------------------------------------------------------
`ifndef TURING_MACHINE_STEPPER_ASSERT_SVH
`define TURING_MACHINE_STEPPER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TMS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/tms_pkg.sv -----
// ---------------------------------------------------------------------------
// tms_pkg
// Shared field widths, item kinds and control structures of the stepper.
// ---------------------------------------------------------------------------
package tms_pkg;

   localparam int SYM_W       = 2;
   localparam int STATE_W     = 4;
   localparam int RULE_ST_W   = 3;
   localparam int COUNT_W     = 48;
   localparam int OFFSET_W    = 12;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [1:0] KIND_LOAD    = 2'd0;
   localparam logic [1:0] KIND_STEP    = 2'd1;
   localparam logic [1:0] KIND_SEEK    = 2'd2;
   localparam logic [1:0] KIND_RESTART = 2'd3;

   // One transition rule as it sits in the rule memory.
   typedef struct packed {
      logic [STATE_W-1:0] next_state;
      logic               move_right;
      logic [SYM_W-1:0]   write_symbol;
   } rule_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear;
   } tape_ctl_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } rule_ctl_type;

   // Machine status as reported in one result word.
   typedef struct packed {
      logic [STATE_W-1:0]         machine_state;
      logic                       halted;
      logic [COUNT_W-1:0]         step_count;
      logic signed [OFFSET_W-1:0] head_offset;
      logic [RULE_ST_W-1:0]       prior_state;
      logic [SYM_W-1:0]           prior_symbol;
      logic                       tape_overflow;
   } status_type;

endpackage

// ----- rtl/tms_tape.sv -----
// ---------------------------------------------------------------------------
// tms_tape
// Tape store: one write and one registered read per cycle, with the span of
// cells written since restart so that untouched cells read as blank.
// ---------------------------------------------------------------------------
module tms_tape
   import tms_pkg::*;
#(
   parameter int TAPE_CELLS = 4096,
   localparam int HW = $clog2(TAPE_CELLS)
) (
   input  logic             clock,
   input  logic             reset,
   input  tape_ctl_type     tape_ctl,
   input  logic [HW-1:0]    rd_addr,
   input  logic [HW-1:0]    wr_addr,
   input  logic [SYM_W-1:0] wr_data,
   output logic [SYM_W-1:0] rd_data
);

   logic [SYM_W-1:0] mem [TAPE_CELLS];
   logic [SYM_W-1:0] q_ff;
   logic             hit_ff;
   logic             hit_in;
   logic [HW-1:0]    lo_ff;
   logic [HW-1:0]    lo_in;
   logic [HW-1:0]    hi_ff;
   logic [HW-1:0]    hi_in;
   logic             any_ff;
   logic             any_in;

   // The head moves one cell at a time, so the written cells always form
   // one contiguous span; anything outside it is still blank.
   assign hit_in = any_ff && (rd_addr >= lo_ff) && (rd_addr <= hi_ff);

   always_comb begin
      lo_in  = lo_ff;
      hi_in  = hi_ff;
      any_in = any_ff;
      if (tape_ctl.clear) begin
         any_in = 1'b0;
      end else if (tape_ctl.wr_en) begin
         any_in = 1'b1;
         lo_in  = (!any_ff || wr_addr < lo_ff) ? wr_addr : lo_ff;
         hi_in  = (!any_ff || wr_addr > hi_ff) ? wr_addr : hi_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (tape_ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (tape_ctl.rd_en) begin
         q_ff   <= mem[rd_addr];
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         any_ff <= 1'b0;
      end else begin
         any_ff <= any_in;
      end
      lo_ff <= lo_in;
      hi_ff <= hi_in;
   end

   assign rd_data = hit_ff ? q_ff : '0;

endmodule

// ----- rtl/tms_rules.sv -----
// ---------------------------------------------------------------------------
// tms_rules
// Rule memory: load words write one sanitized rule, steps read one rule with
// a registered read.
// ---------------------------------------------------------------------------
module tms_rules
   import tms_pkg::*;
#(
   parameter int NUM_STATES  = 8,
   parameter int NUM_SYMBOLS = 4,
   localparam int RULE_COUNT = NUM_STATES * NUM_SYMBOLS,
   localparam int RIW        = $clog2(RULE_COUNT)
) (
   input  logic                 clock,
   input  rule_ctl_type         rule_ctl,
   input  logic [RULE_ST_W-1:0] ld_state,
   input  logic [SYM_W-1:0]     ld_symbol,
   input  logic [SYM_W-1:0]     ld_write_symbol,
   input  logic                 ld_move_right,
   input  logic [STATE_W-1:0]   ld_target_state,
   input  logic [STATE_W-1:0]   rd_state,
   input  logic [SYM_W-1:0]     rd_symbol,
   output rule_type             rd_rule
);

   rule_type       mem [RULE_COUNT];
   rule_type       q_ff;
   rule_type       ld_rule;
   logic           ld_ok;
   logic [RIW-1:0] ld_idx;
   logic [RIW-1:0] rd_idx;

   // A load outside the table is dropped; an unknown symbol is stored as
   // blank and a target past the halt state is stored as halt.
   assign ld_ok = (32'(ld_state) < NUM_STATES) && (32'(ld_symbol) < NUM_SYMBOLS);
   assign ld_idx = RIW'(32'(ld_state) * NUM_SYMBOLS + 32'(ld_symbol));
   assign rd_idx = RIW'(32'(rd_state) * NUM_SYMBOLS + 32'(rd_symbol));

   always_comb begin
      ld_rule.write_symbol = (32'(ld_write_symbol) >= NUM_SYMBOLS) ? '0 : ld_write_symbol;
      ld_rule.move_right   = ld_move_right;
      ld_rule.next_state   = (32'(ld_target_state) > NUM_STATES)
                             ? STATE_W'(NUM_STATES) : ld_target_state;
   end

   always_ff @(posedge clock) begin
      if (rule_ctl.wr_en && ld_ok) begin
         mem[ld_idx] <= ld_rule;
      end
      if (rule_ctl.rd_en) begin
         q_ff <= mem[rd_idx];
      end
   end

   assign rd_rule = q_ff;

endmodule

// ----- rtl/tms_seq.sv -----
// ---------------------------------------------------------------------------
// tms_seq
// Step sequencer and machine registers: reads the tape, looks up the rule,
// writes back and moves the head, and repeats for a seek.
// ---------------------------------------------------------------------------
`include "turing_machine_stepper_assert.svh"

module tms_seq
   import tms_pkg::*;
#(
   parameter int TAPE_CELLS = 4096,
   parameter int NUM_STATES = 8,
   localparam int HW = $clog2(TAPE_CELLS)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_fire,
   input  logic [1:0]         req_kind,
   input  logic [COUNT_W-1:0] req_step_goal,
   input  logic               rsp_take,
   input  logic [SYM_W-1:0]   tape_rd_data,
   input  rule_type           rule_q,
   output tape_ctl_type       tape_ctl,
   output logic [HW-1:0]      tape_rd_addr,
   output logic [HW-1:0]      tape_wr_addr,
   output logic [SYM_W-1:0]   tape_wr_data,
   output rule_ctl_type       rule_ctl,
   output logic [STATE_W-1:0] rule_rd_state,
   output logic [SYM_W-1:0]   rule_rd_symbol,
   output status_type         status,
   output logic               idle,
   output logic               done
);

   localparam logic [1:0] SEQ_IDLE  = 2'd0;
   localparam logic [1:0] SEQ_RULE  = 2'd1;
   localparam logic [1:0] SEQ_APPLY = 2'd2;
   localparam logic [1:0] SEQ_DONE  = 2'd3;

   localparam logic [HW-1:0] HEAD_START = HW'(TAPE_CELLS / 2);
   localparam logic [HW-1:0] HEAD_LAST  = HW'(TAPE_CELLS - 1);
   localparam int DW = ((HW > OFFSET_W) ? HW : OFFSET_W) + 1;

   logic [1:0]           seq_ff, seq_in;
   logic                 seek_ff, seek_in;
   logic [COUNT_W-1:0]   goal_ff, goal_in;
   logic [SYM_W-1:0]     sym_ff, sym_in;
   logic [STATE_W-1:0]   state_ff, state_in;
   logic [HW-1:0]        head_ff, head_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [RULE_ST_W-1:0] last_state_ff, last_state_in;
   logic [SYM_W-1:0]     last_sym_ff, last_sym_in;
   logic                 ovf_ff, ovf_in;

   logic                 halted;
   logic                 can_step;
   logic                 go;
   logic                 bound_hit;
   logic [HW-1:0]        head_next;
   logic [DW-1:0]        off_wide;

   assign halted   = 32'(state_ff) >= NUM_STATES;
   assign can_step = !halted && !ovf_ff && (count_ff != COUNT_MAX);
   assign go       = can_step && (!seek_ff || (count_ff < goal_ff));

   // Head move of the rule being applied; at either end the head stays.
   always_comb begin
      if (rule_q.move_right) begin
         bound_hit = (head_ff == HEAD_LAST);
         head_next = bound_hit ? head_ff : head_ff + 1'b1;
      end else begin
         bound_hit = (head_ff == '0);
         head_next = bound_hit ? head_ff : head_ff - 1'b1;
      end
   end

   always_comb begin
      seq_in        = seq_ff;
      seek_in       = seek_ff;
      goal_in       = goal_ff;
      sym_in        = sym_ff;
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      last_state_in = last_state_ff;
      last_sym_in   = last_sym_ff;
      ovf_in        = ovf_ff;
      tape_ctl      = '0;
      rule_ctl      = '0;
      tape_rd_addr  = head_ff;
      unique case (seq_ff)
         SEQ_IDLE: begin
            if (req_fire) begin
               tape_ctl.rd_en = 1'b1;
               unique case (req_kind)
                  KIND_LOAD: begin
                     rule_ctl.wr_en = 1'b1;
                     seq_in         = SEQ_DONE;
                  end
                  KIND_STEP: begin
                     seek_in = 1'b0;
                     seq_in  = SEQ_RULE;
                  end
                  KIND_SEEK: begin
                     seek_in = 1'b1;
                     goal_in = req_step_goal;
                     seq_in  = SEQ_RULE;
                  end
                  KIND_RESTART: begin
                     tape_ctl.clear = 1'b1;
                     state_in       = '0;
                     head_in        = HEAD_START;
                     count_in       = '0;
                     last_state_in  = '0;
                     last_sym_in    = '0;
                     ovf_in         = 1'b0;
                     seq_in         = SEQ_DONE;
                  end
               endcase
            end
         end
         SEQ_RULE: begin
            if (go) begin
               rule_ctl.rd_en = 1'b1;
               sym_in         = tape_rd_data;
               seq_in         = SEQ_APPLY;
            end else begin
               seq_in = SEQ_DONE;
            end
         end
         SEQ_APPLY: begin
            tape_ctl.wr_en = 1'b1;
            last_state_in  = state_ff[RULE_ST_W-1:0];
            last_sym_in    = sym_ff;
            state_in       = rule_q.next_state;
            head_in        = head_next;
            ovf_in         = bound_hit;
            count_in       = count_ff + 1'b1;
            if (seek_ff) begin
               // Fetch the next cell while this one is written back.
               tape_ctl.rd_en = 1'b1;
               tape_rd_addr   = head_next;
               seq_in         = SEQ_RULE;
            end else begin
               seq_in = SEQ_DONE;
            end
         end
         SEQ_DONE: begin
            if (rsp_take) begin
               seq_in = SEQ_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff        <= SEQ_IDLE;
         state_ff      <= '0;
         head_ff       <= HEAD_START;
         count_ff      <= '0;
         last_state_ff <= '0;
         last_sym_ff   <= '0;
         ovf_ff        <= 1'b0;
      end else begin
         seq_ff        <= seq_in;
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         last_state_ff <= last_state_in;
         last_sym_ff   <= last_sym_in;
         ovf_ff        <= ovf_in;
      end
      seek_ff <= seek_in;
      goal_ff <= goal_in;
      sym_ff  <= sym_in;
   end

   assign tape_wr_addr   = head_ff;
   assign tape_wr_data   = rule_q.write_symbol;
   assign rule_rd_state  = state_ff;
   assign rule_rd_symbol = tape_rd_data;

   assign off_wide = DW'(head_ff) - DW'(HEAD_START);

   always_comb begin
      status.machine_state = state_ff;
      status.halted        = halted;
      status.step_count    = count_ff;
      status.head_offset   = off_wide[OFFSET_W-1:0];
      status.prior_state   = last_state_ff;
      status.prior_symbol  = last_sym_ff;
      status.tape_overflow = ovf_ff;
   end

   assign idle = (seq_ff == SEQ_IDLE);
   assign done = (seq_ff == SEQ_DONE);

   `TMS_ASSERT_SAME(a_apply_allowed, clock, reset, seq_ff == SEQ_APPLY, can_step, "step applied while the machine may not step")
   `TMS_ASSERT_NEXT(a_count_step, clock, reset, seq_ff == SEQ_APPLY, count_ff == $past(count_ff) + 1'b1, "step count did not advance by one")
   `TMS_ASSERT_SAME(a_seek_goal, clock, reset, seq_ff == SEQ_APPLY && seek_ff, count_ff < goal_ff, "seek stepped at or past its goal")

endmodule

// ----- rtl/turing_machine_stepper.sv -----
// ---------------------------------------------------------------------------
// turing_machine_stepper
// Turing machine simulator: rule loads, single steps, seeks to a step goal
// and restarts, each answered by one status word.
// ---------------------------------------------------------------------------
//
//   Channel   Handshake              Word
//   req_      req_valid / req_stall  kind, rule fields, step goal
//   rsp_      rsp_valid / rsp_stall  state, halt, count, head, prior step, overflow
//
// A load or restart word goes from acceptance straight to the done state.
// A step passes through the rule lookup and apply states; a seek repeats
// them for every step it runs. Each machine step needs a tape read and then
// a rule read: both are synchronous memory reads that depend on each other.
// Synchronous reset blanks the tape at once: only the span of cells written
// since restart is read from the tape memory, so there is no clearing pass.
// A stalled result sits in the output register while the next word is taken.
//
module turing_machine_stepper
   import tms_pkg::*;
#(
   parameter int TAPE_CELLS  = 4096,
   parameter int NUM_STATES  = 8,
   parameter int NUM_SYMBOLS = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_kind,
   input  logic [RULE_ST_W-1:0]        req_rule_state,
   input  logic [SYM_W-1:0]            req_rule_symbol,
   input  logic [SYM_W-1:0]            req_write_symbol,
   input  logic                        req_move_right,
   input  logic [STATE_W-1:0]          req_target_state,
   input  logic [COUNT_W-1:0]          req_step_goal,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [STATE_W-1:0]          rsp_machine_state,
   output logic                        rsp_halted,
   output logic [COUNT_W-1:0]          rsp_step_count,
   output logic signed [OFFSET_W-1:0]  rsp_head_offset,
   output logic [RULE_ST_W-1:0]        rsp_prior_state,
   output logic [SYM_W-1:0]            rsp_prior_symbol,
   output logic                        rsp_tape_overflow
);

   localparam int HW = $clog2(TAPE_CELLS);

   // Sequencer to memories.
   tape_ctl_type       tape_ctl;
   logic [HW-1:0]      tape_rd_addr;
   logic [HW-1:0]      tape_wr_addr;
   logic [SYM_W-1:0]   tape_wr_data;
   logic [SYM_W-1:0]   tape_rd_data;
   rule_ctl_type       rule_ctl;
   logic [STATE_W-1:0] rule_rd_state;
   logic [SYM_W-1:0]   rule_rd_symbol;
   rule_type           rule_q;

   // Handshake and status.
   status_type         status;
   logic               idle;
   logic               done;
   logic               req_fire;
   logic               rsp_take;
   logic               rsp_valid_ff;
   status_type         rsp_data_ff;

   // A word is taken only while the sequencer is idle; the machine is
   // busy from acceptance until its result is loaded into the output.
   assign req_stall = !idle;
   assign req_fire  = req_valid && !req_stall;

   // The finished status moves into the output register once that register
   // is empty or is being emptied in the same cycle.
   assign rsp_take = done && (!rsp_valid_ff || !rsp_stall);

   tms_seq #(
      .TAPE_CELLS (TAPE_CELLS),
      .NUM_STATES (NUM_STATES)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_fire       (req_fire),
      .req_kind       (req_kind),
      .req_step_goal  (req_step_goal),
      .rsp_take       (rsp_take),
      .tape_rd_data   (tape_rd_data),
      .rule_q         (rule_q),
      .tape_ctl       (tape_ctl),
      .tape_rd_addr   (tape_rd_addr),
      .tape_wr_addr   (tape_wr_addr),
      .tape_wr_data   (tape_wr_data),
      .rule_ctl       (rule_ctl),
      .rule_rd_state  (rule_rd_state),
      .rule_rd_symbol (rule_rd_symbol),
      .status         (status),
      .idle           (idle),
      .done           (done)
   );

   tms_tape #(
      .TAPE_CELLS (TAPE_CELLS)
   ) u_tape (
      .clock    (clock),
      .reset    (reset),
      .tape_ctl (tape_ctl),
      .rd_addr  (tape_rd_addr),
      .wr_addr  (tape_wr_addr),
      .wr_data  (tape_wr_data),
      .rd_data  (tape_rd_data)
   );

   tms_rules #(
      .NUM_STATES  (NUM_STATES),
      .NUM_SYMBOLS (NUM_SYMBOLS)
   ) u_rules (
      .clock           (clock),
      .rule_ctl        (rule_ctl),
      .ld_state        (req_rule_state),
      .ld_symbol       (req_rule_symbol),
      .ld_write_symbol (req_write_symbol),
      .ld_move_right   (req_move_right),
      .ld_target_state (req_target_state),
      .rd_state        (rule_rd_state),
      .rd_symbol       (rule_rd_symbol),
      .rd_rule         (rule_q)
   );

   // Output register: holds one result word until the consumer takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_take) begin
         rsp_data_ff <= status;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_machine_state = rsp_data_ff.machine_state;
   assign rsp_halted        = rsp_data_ff.halted;
   assign rsp_step_count    = rsp_data_ff.step_count;
   assign rsp_head_offset   = rsp_data_ff.head_offset;
   assign rsp_prior_state   = rsp_data_ff.prior_state;
   assign rsp_prior_symbol  = rsp_data_ff.prior_symbol;
   assign rsp_tape_overflow = rsp_data_ff.tape_overflow;

endmodule

// ----- dv/turing_machine_stepper_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// turing_machine_stepper_tb
// Self-checking bench for the Turing machine stepper. A behavioral copy of
// the machine predicts the status word of every accepted request, and each
// result word is compared field by field with the oldest prediction. Short
// hand-built programs cover halting, seek goals and both tape ends. Random
// rule tables follow, with bursts of idling on both channels and one long
// result hold-off.
// ---------------------------------------------------------------------------
module turing_machine_stepper_tb
   import tms_pkg::*;
();

   localparam int TAPE_CELLS  = 4096;
   localparam int NUM_STATES  = 8;
   localparam int NUM_SYMBOLS = 4;
   localparam int HEAD_START  = TAPE_CELLS / 2;
   localparam int RULE_COUNT  = NUM_STATES * NUM_SYMBOLS;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [1:0]                 req_kind = KIND_LOAD;
   logic [RULE_ST_W-1:0]       req_rule_state = '0;
   logic [SYM_W-1:0]           req_rule_symbol = '0;
   logic [SYM_W-1:0]           req_write_symbol = '0;
   logic                       req_move_right = 1'b0;
   logic [STATE_W-1:0]         req_target_state = '0;
   logic [COUNT_W-1:0]         req_step_goal = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [STATE_W-1:0]         rsp_machine_state;
   logic                       rsp_halted;
   logic [COUNT_W-1:0]         rsp_step_count;
   logic signed [OFFSET_W-1:0] rsp_head_offset;
   logic [RULE_ST_W-1:0]       rsp_prior_state;
   logic [SYM_W-1:0]           rsp_prior_symbol;
   logic                       rsp_tape_overflow;

   // Behavioral copy of the machine, kept in step with every accepted word.
   logic [SYM_W-1:0]     tape_model [0:TAPE_CELLS-1];
   rule_type             rule_model [0:RULE_COUNT-1];
   logic [STATE_W-1:0]   state_model;
   int                   head_model;
   logic [COUNT_W-1:0]   count_model;
   logic [RULE_ST_W-1:0] prior_state_model;
   logic [SYM_W-1:0]     prior_symbol_model;
   logic                 overflow_model;

   // Status words predicted but not yet seen on the result channel.
   status_type pending_status [$];

   int error_count = 0;
   bit idle_on = 1'b0;
   int hold_request = 0;
   // Long seeks are slow to run, so only a few are allowed.
   int big_seeks_left = 40;

   turing_machine_stepper #(
      .TAPE_CELLS (TAPE_CELLS),
      .NUM_STATES (NUM_STATES),
      .NUM_SYMBOLS(NUM_SYMBOLS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_rule_state   (req_rule_state),
      .req_rule_symbol  (req_rule_symbol),
      .req_write_symbol (req_write_symbol),
      .req_move_right   (req_move_right),
      .req_target_state (req_target_state),
      .req_step_goal    (req_step_goal),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_machine_state(rsp_machine_state),
      .rsp_halted       (rsp_halted),
      .rsp_step_count   (rsp_step_count),
      .rsp_head_offset  (rsp_head_offset),
      .rsp_prior_state  (rsp_prior_state),
      .rsp_prior_symbol (rsp_prior_symbol),
      .rsp_tape_overflow(rsp_tape_overflow)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Machine prediction
   // -------------------------------------------------------------------------

   // Restart blanks the tape and returns the machine to its initial state.
   // The rule table is left alone.
   function automatic void restart_model();
      for (int i = 0; i < TAPE_CELLS; i++) tape_model[i] = '0;
      state_model        = '0;
      head_model         = HEAD_START;
      count_model        = '0;
      prior_state_model  = '0;
      prior_symbol_model = '0;
      overflow_model     = 1'b0;
   endfunction

   // The machine moves only while it is not halted, has not run off the
   // tape and its count is below the ceiling of 2^48-1 steps.
   function automatic bit machine_can_run();
      return (state_model < NUM_STATES) && !overflow_model && (count_model != COUNT_MAX);
   endfunction

   // One machine step: read, look up, write, move, change state, count.
   function automatic void machine_step();
      logic [SYM_W-1:0] sym;
      rule_type         rule;
      sym  = tape_model[head_model];
      rule = rule_model[{state_model[RULE_ST_W-1:0], sym}];
      prior_state_model  = state_model[RULE_ST_W-1:0];
      prior_symbol_model = sym;
      tape_model[head_model] = rule.write_symbol;
      // A move off either end leaves the head there and flags the overflow,
      // but the rest of the step still takes effect.
      if (rule.move_right) begin
         if (head_model == TAPE_CELLS - 1) overflow_model = 1'b1;
         else head_model++;
      end else begin
         if (head_model == 0) overflow_model = 1'b1;
         else head_model--;
      end
      state_model = rule.next_state;
      count_model = count_model + 1'b1;
   endfunction

   // Applies one accepted request word to the model and queues the status
   // word that the block must answer with.
   task automatic predict_word(input logic [1:0] kind, input logic [RULE_ST_W-1:0] r_state,
                               input logic [SYM_W-1:0] r_symbol, input logic [SYM_W-1:0] w_symbol,
                               input logic move, input logic [STATE_W-1:0] target,
                               input logic [COUNT_W-1:0] goal);
      rule_type   rule;
      status_type status;
      int         offset;
      case (kind)
         KIND_LOAD: begin
            // Any target beyond the halt state is stored as halt.
            rule.write_symbol = w_symbol;
            rule.move_right   = move;
            if (target > NUM_STATES) rule.next_state = STATE_W'(NUM_STATES);
            else rule.next_state = target;
            rule_model[{r_state, r_symbol}] = rule;
         end
         KIND_STEP: begin
            if (machine_can_run()) machine_step();
         end
         KIND_SEEK: begin
            // A goal at or below the current count runs no step at all.
            while (machine_can_run() && count_model < goal) machine_step();
         end
         default: begin
            restart_model();
         end
      endcase
      offset = head_model - HEAD_START;
      status.machine_state = state_model;
      status.halted        = (state_model >= NUM_STATES);
      status.step_count    = count_model;
      status.head_offset   = offset[OFFSET_W-1:0];
      status.prior_state   = prior_state_model;
      status.prior_symbol  = prior_symbol_model;
      status.tape_overflow = overflow_model;
      pending_status.push_back(status);
   endtask

   // -------------------------------------------------------------------------
   // Request channel
   // -------------------------------------------------------------------------

   // Offers one request word, with an optional idle burst in front of it,
   // and predicts its result once the block has taken it. Inputs change only
   // at the falling edge; the stall is sampled at the rising edge.
   task automatic send_word(input logic [1:0] kind, input logic [RULE_ST_W-1:0] r_state,
                            input logic [SYM_W-1:0] r_symbol, input logic [SYM_W-1:0] w_symbol,
                            input logic move, input logic [STATE_W-1:0] target,
                            input logic [COUNT_W-1:0] goal);
      int gap;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        = 1'b1;
      req_kind         = kind;
      req_rule_state   = r_state;
      req_rule_symbol  = r_symbol;
      req_write_symbol = w_symbol;
      req_move_right   = move;
      req_target_state = target;
      req_step_goal    = goal;
      do @(posedge clock); while (req_stall);
      predict_word(kind, r_state, r_symbol, w_symbol, move, target, goal);
   endtask

   function automatic logic [COUNT_W-1:0] random_goal_bits();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      return bits[COUNT_W-1:0];
   endfunction

   // Step, seek and restart words carry random rule fields, which the block
   // must ignore.
   task automatic send_op(input logic [1:0] kind, input logic [COUNT_W-1:0] goal);
      send_word(kind, RULE_ST_W'($urandom_range(0, 7)), SYM_W'($urandom_range(0, 3)),
                SYM_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                STATE_W'($urandom_range(0, 15)), goal);
   endtask

   task automatic load_rule(input int r_state, input int r_symbol, input int w_symbol,
                            input int move, input int target);
      send_word(KIND_LOAD, RULE_ST_W'(r_state), SYM_W'(r_symbol), SYM_W'(w_symbol),
                1'(move), STATE_W'(target), random_goal_bits());
   endtask

   // A marching rule always moves the same way and never halts, so the head
   // drifts toward one end of the tape. Other rules halt now and then, with
   // the halt code and the codes above it both in use.
   task automatic load_random_rule(input int r_state, input int r_symbol, input bit marching,
                                   input bit to_right);
      int move;
      int target;
      move = marching ? to_right : $urandom_range(0, 1);
      if (!marching && $urandom_range(0, 7) == 0) target = $urandom_range(NUM_STATES, 15);
      else target = $urandom_range(0, NUM_STATES - 1);
      load_rule(r_state, r_symbol, $urandom_range(0, 3), move, target);
   endtask

   // Chooses a seek goal that keeps the run finite: fully random goals only
   // where the machine cannot move, otherwise a goal a little ahead of the
   // count, now and then one far ahead, and sometimes one already passed.
   function automatic logic [COUNT_W-1:0] pick_goal(input bit marching);
      int back;
      if (!machine_can_run()) return random_goal_bits();
      if ($urandom_range(0, 7) == 0) begin
         back = $urandom_range(0, 16);
         if (back > count_model) back = int'(count_model);
         return count_model - back;
      end
      if (big_seeks_left > 0 && $urandom_range(0, marching ? 2 : 31) == 0) begin
         big_seeks_left--;
         return count_model + $urandom_range(64, 2600);
      end
      return count_model + $urandom_range(1, 48);
   endfunction

   // Holds the request channel idle until every predicted result is back.
   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Result channel
   // -------------------------------------------------------------------------

   // Random stall bursts while idling is on; a requested hold-off is counted
   // down here, one cycle per falling edge.
   initial begin : result_receiver
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_stall = 1'b1;
            stall_left--;
         end else begin
            rsp_stall = 1'b0;
            if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 14);
         end
      end
   end

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : result_checker
      status_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_status.size() == 0) begin
            error_count++;
            $display("%0t: result word with no request pending, expected none, actual state %0h",
                     $time, rsp_machine_state);
         end else begin
            want = pending_status.pop_front();
            check_field("machine_state", 64'(want.machine_state), 64'(rsp_machine_state));
            check_field("halted", 64'(want.halted), 64'(rsp_halted));
            check_field("step_count", 64'(want.step_count), 64'(rsp_step_count));
            check_field("head_offset", 64'(want.head_offset), 64'(rsp_head_offset));
            check_field("prior_state", 64'(want.prior_state), 64'(rsp_prior_state));
            check_field("prior_symbol", 64'(want.prior_symbol), 64'(rsp_prior_symbol));
            check_field("tape_overflow", 64'(want.tape_overflow), 64'(rsp_tape_overflow));
         end
      end
   end

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Two rules: the machine writes, moves right, then halts one step later
   // through a target code above the halt state. The first word also shows
   // the status straight out of reset.
   task automatic test_halting_program();
      load_rule(0, 0, 3, 1, 1);
      load_rule(1, 0, 1, 0, 9);
      send_op(KIND_STEP, '0);
      send_op(KIND_STEP, '0);
      // Halted: neither a step nor a seek to the farthest goal moves it.
      send_op(KIND_STEP, '0);
      send_op(KIND_SEEK, COUNT_MAX);
      send_op(KIND_RESTART, '0);
      // A goal of zero, then a goal equal to the count, run no steps.
      send_op(KIND_SEEK, '0);
      send_op(KIND_STEP, '0);
      send_op(KIND_SEEK, 48'd1);
      // A far goal stops as soon as the machine halts.
      send_op(KIND_SEEK, COUNT_MAX);
      send_op(KIND_RESTART, '0);
   endtask

   // Corner codes of the rule fields. These rules are never used before the
   // random tables overwrite them.
   task automatic test_rule_extremes();
      load_rule(7, 3, 3, 1, 15);
      load_rule(6, 2, 0, 0, NUM_STATES);
   endtask

   // A single rule marching over blank cells runs the head off one end.
   task automatic test_tape_overflow();
      load_rule(0, 0, 2, 1, 0);
      send_op(KIND_SEEK, COUNT_MAX);
      // Once off the tape the machine is frozen until a restart.
      send_op(KIND_STEP, '0);
      send_op(KIND_SEEK, COUNT_MAX);
      send_op(KIND_RESTART, '0);
      load_rule(0, 0, 1, 0, 0);
      send_op(KIND_SEEK, COUNT_MAX);
      send_op(KIND_RESTART, '0);
      drain_results();
   endtask

   // Writes a whole random table, restarts and then mixes loads, steps,
   // seeks and restarts. Every rule is written before the first step, so no
   // step ever reads an unloaded rule.
   task automatic run_random_phase(input int n_words, input bit marching, input bit to_right);
      int pick;
      for (int st = 0; st < NUM_STATES; st++)
         for (int sy = 0; sy < NUM_SYMBOLS; sy++)
            load_random_rule(st, sy, marching, to_right);
      send_op(KIND_RESTART, random_goal_bits());
      repeat (n_words) begin
         pick = $urandom_range(0, 99);
         if (pick < 12)
            load_random_rule($urandom_range(0, 7), $urandom_range(0, 3), marching, to_right);
         else if (pick < 45)
            send_op(KIND_STEP, random_goal_bits());
         else if (pick < (marching ? 97 : 86))
            send_op(KIND_SEEK, pick_goal(marching));
         else
            send_op(KIND_RESTART, random_goal_bits());
      end
      drain_results();
   endtask

   task automatic test_random_programs();
      idle_on = 1'b1;
      repeat (4) run_random_phase(250, 1'b0, 1'b0);
   endtask

   // Tables that drift one way reach the tape ends through long seeks.
   task automatic test_marching_programs();
      idle_on = 1'b1;
      run_random_phase(200, 1'b1, 1'b1);
      run_random_phase(200, 1'b1, 1'b0);
   endtask

   // The receiver holds off for a long stretch while requests keep coming,
   // so the block fills and stalls its request channel.
   task automatic test_output_backpressure();
      idle_on      = 1'b1;
      hold_request = 400;
      run_random_phase(250, 1'b0, 1'b0);
   endtask

   // Closing stretch with both channels running flat out.
   task automatic test_full_rate();
      idle_on = 1'b0;
      run_random_phase(250, 1'b0, 1'b0);
   endtask

   initial begin
      restart_model();
      for (int i = 0; i < RULE_COUNT; i++) rule_model[i] = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_halting_program();
      test_rule_extremes();
      test_tape_overflow();
      test_random_programs();
      test_marching_programs();
      test_output_backpressure();
      test_full_rate();

      drain_results();
      // Any stray word after the last expected one is caught here.
      repeat (16) @(posedge clock);
      if (error_count == 0) $display("turing_machine_stepper test passed");
      else $display("turing_machine_stepper test failed");
      $finish;
   end

   // Far beyond the slowest correct run, long seeks and stalls included.
   initial begin
      #20_000_000;
      $display("turing_machine_stepper test failed");
      $finish;
   end

endmodule

// ----- turing_machine_stepper.f -----
+incdir+rtl
rtl/tms_pkg.sv
rtl/tms_tape.sv
rtl/tms_rules.sv
rtl/tms_seq.sv
rtl/turing_machine_stepper.sv
dv/turing_machine_stepper_tb.sv
